/* rtl/core/button_click_counter_defines.svh */
// Assertion helpers for the button click counter RTL.
`ifndef BUTTON_CLICK_COUNTER_DEFINES_SVH
`define BUTTON_CLICK_COUNTER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define BCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define BCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bcc_pkg.sv */
package bcc_pkg;

  localparam int unsigned TICK_BITS_DEF = 32;
  localparam int unsigned TIMEOUT_W     = 32;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned RES_W         = 18;
  localparam int unsigned OUT_TDATA_W   = 24;

  localparam logic [7:0]           CLICK_MAX          = 8'hFF;
  localparam logic                 ACTIVE_LEVEL_RESET = 1'b0;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET      = 32'd300;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVEL  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_TIMEOUT = 1'd1;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_LOCK   = 2'd1,
    OP_UNLOCK = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    LCHG_NONE   = 2'd0,
    LCHG_LOCK   = 2'd1,
    LCHG_UNLOCK = 2'd2
  } lchg_e;

  typedef struct packed {
    logic       locked;
    logic       held;
    logic       let_go;
    logic       counting;
    logic       done;
    logic [7:0] clicks;
  } flags_t;

  // Packed so that press_event lands in bit 0.
  typedef struct packed {
    lchg_e      lock_change;
    logic       is_locked;
    logic       is_pressed;
    logic [7:0] click_count;
    logic       click_cleared;
    logic       click_finished;
    logic       click_more;
    logic       click_start;
    logic       release_event;
    logic       press_event;
  } result_t;

  localparam flags_t FLAGS_RESET = '{
    locked: 1'b1, held: 1'b0, let_go: 1'b0, counting: 1'b0, done: 1'b0, clicks: 8'd0
  };

endpackage

/* rtl/core/bcc_step.sv */
module bcc_step #(
  parameter int unsigned TICK_BITS = bcc_pkg::TICK_BITS_DEF
) (
  input  bcc_pkg::op_e                    op_i,
  input  logic                            level_i,
  input  logic                            active_level_i,
  input  logic [bcc_pkg::TIMEOUT_W-1:0]   timeout_i,
  input  bcc_pkg::flags_t                 flags_i,
  input  logic [TICK_BITS-1:0]            edge_time_i,
  input  logic [TICK_BITS-1:0]            tick_now_i,
  output bcc_pkg::flags_t                 flags_o,
  output logic [TICK_BITS-1:0]            edge_time_o,
  output logic [TICK_BITS-1:0]            tick_now_o,
  output bcc_pkg::result_t                result_o
);

  localparam int unsigned CMP_W =
    (TICK_BITS > bcc_pkg::TIMEOUT_W) ? TICK_BITS : bcc_pkg::TIMEOUT_W;

  logic                 act;
  logic                 skip;
  logic [TICK_BITS-1:0] elapsed;

  always_comb begin
    flags_o     = flags_i;
    edge_time_o = edge_time_i;
    tick_now_o  = tick_now_i;
    result_o    = '0;
    act         = (level_i == active_level_i);
    skip        = 1'b0;
    elapsed     = '0;

    unique case (op_i)
      bcc_pkg::OP_LOCK: begin
        flags_o.locked       = 1'b1;
        result_o.lock_change = bcc_pkg::LCHG_LOCK;
      end
      bcc_pkg::OP_UNLOCK: begin
        flags_o.locked       = 1'b0;
        result_o.lock_change = bcc_pkg::LCHG_UNLOCK;
      end
      bcc_pkg::OP_CLEAR: begin
        flags_o.locked = 1'b0;
        flags_o.held   = 1'b0;
        flags_o.let_go = 1'b0;
      end
      bcc_pkg::OP_TICK: begin
        // Locked: ignore a held button, unlock once it reads released.
        skip = flags_i.locked && act;
        if (flags_i.locked && !act) begin
          flags_o.locked = 1'b0;
          flags_o.held   = 1'b0;
          flags_o.let_go = 1'b0;
        end

        if (!skip) begin
          if (act) begin
            if (!flags_o.held) begin
              flags_o.held         = 1'b1;
              edge_time_o          = tick_now_i;
              result_o.press_event = 1'b1;
            end
          end else if (!flags_o.let_go) begin
            if (flags_o.held) begin
              flags_o.held           = 1'b0;
              flags_o.let_go         = 1'b1;
              edge_time_o            = tick_now_i;
              result_o.release_event = 1'b1;
            end
          end else begin
            // Drop the one-tick release pulse.
            flags_o.locked = 1'b0;
            flags_o.held   = 1'b0;
            flags_o.let_go = 1'b0;
          end
        end

        elapsed = tick_now_i - edge_time_o;

        priority if (flags_o.done) begin
          flags_o.done           = 1'b0;
          flags_o.counting       = 1'b0;
          result_o.click_cleared = 1'b1;
        end else if (flags_o.let_go) begin
          if (flags_o.counting) begin
            if (flags_o.clicks != bcc_pkg::CLICK_MAX) begin
              flags_o.clicks = flags_o.clicks + 8'd1;
            end
            result_o.click_more = 1'b1;
          end else begin
            flags_o.counting     = 1'b1;
            flags_o.clicks       = 8'd1;
            result_o.click_start = 1'b1;
          end
        end else begin
          if (!flags_o.held && flags_o.counting &&
              (CMP_W'(elapsed) >= CMP_W'(timeout_i))) begin
            flags_o.done            = 1'b1;
            result_o.click_finished = 1'b1;
          end
        end

        tick_now_o = tick_now_i + TICK_BITS'(1);
      end
    endcase

    result_o.click_count = flags_o.clicks;
    result_o.is_pressed  = flags_o.held;
    result_o.is_locked   = flags_o.locked;
  end

endmodule

/* rtl/core/button_click_counter.sv */
// Two register stages: the input stage holds an accepted item, the result stage its result.
// One item per clock unless results stall; state update and subtract-compare share a stage.
// Backpressure on the result side stalls the input stage in the same cycle.
// Reset (rst_ni low, asynchronous): both stages empty, button locked, flags, counts and
// the tick counter cleared, active_level 0 and click_timeout 300.
`include "button_click_counter_defines.svh"

module button_click_counter #(
  parameter int unsigned TICK_BITS = bcc_pkg::TICK_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bcc_pkg::CFG_DATA_W-1:0]     cfg_data_i,

  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [0] level, [7:1] zero
  input  logic [7:0]                         s_axis_tdata,
  // [1:0] op
  input  logic [1:0]                         s_axis_tuser,

  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] press_event, [1] release_event, [2] click_start, [3] click_more,
  // [4] click_finished, [5] click_cleared, [13:6] click_count, [14] is_pressed,
  // [15] is_locked, [17:16] lock_change, [23:18] zero
  output logic [bcc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  logic                            active_level_q;
  logic [bcc_pkg::TIMEOUT_W-1:0]   timeout_q;

  logic                            in_valid_q;
  bcc_pkg::op_e                    in_op_q;
  logic                            in_level_q;

  logic                            out_valid_q;
  bcc_pkg::result_t                out_q;

  bcc_pkg::flags_t                 flags_q, flags_d;
  logic [TICK_BITS-1:0]            edge_q, edge_d;
  logic [TICK_BITS-1:0]            tick_q, tick_d;
  bcc_pkg::result_t                res_d;

  logic                            advance;
  logic                            fire;

  assign cfg_ready_o   = 1'b1;
  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_level_q <= bcc_pkg::ACTIVE_LEVEL_RESET;
      timeout_q      <= bcc_pkg::TIMEOUT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bcc_pkg::CFG_ACTIVE_LEVEL:  active_level_q <= cfg_data_i[0];
        bcc_pkg::CFG_CLICK_TIMEOUT: timeout_q      <= cfg_data_i[bcc_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_op_q    <= bcc_pkg::OP_TICK;
      in_level_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_op_q    <= bcc_pkg::op_e'(s_axis_tuser);
      in_level_q <= s_axis_tdata[0];
    end
  end

  bcc_step #(
    .TICK_BITS (TICK_BITS)
  ) u_step (
    .op_i           (in_op_q),
    .level_i        (in_level_q),
    .active_level_i (active_level_q),
    .timeout_i      (timeout_q),
    .flags_i        (flags_q),
    .edge_time_i    (edge_q),
    .tick_now_i     (tick_q),
    .flags_o        (flags_d),
    .edge_time_o    (edge_d),
    .tick_now_o     (tick_d),
    .result_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= bcc_pkg::FLAGS_RESET;
      edge_q      <= '0;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        flags_q <= flags_d;
        edge_q  <= edge_d;
        tick_q  <= tick_d;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(bcc_pkg::OUT_TDATA_W - bcc_pkg::RES_W)'(0), out_q};

  `BCC_ASSERT_IMP(a_done_needs_counting, flags_q.done, flags_q.counting,
                  "done set while not counting")
  `BCC_ASSERT_IMP(a_counting_has_clicks, flags_q.counting, flags_q.clicks != 8'd0,
                  "counting with zero clicks")
  `BCC_ASSERT_IMP(a_click_events_exclusive, m_axis_tvalid,
                  $onehot0({out_q.click_start, out_q.click_more,
                            out_q.click_finished, out_q.click_cleared}),
                  "more than one click event in a result")
  `BCC_ASSERT_NXT(a_fire_fills_output, fire, m_axis_tvalid,
                  "processed item did not reach the result stage")

endmodule

/* verif/button_click_counter_tb.sv */
module button_click_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Expected-result store and item-by-item copy of the click logic.
  class click_scoreboard;
    logic                          act_level;
    logic [bcc_pkg::TIMEOUT_W-1:0] timeout;
    logic                          locked;
    logic                          held;
    logic                          let_go;
    logic [31:0]                   edge_tick;
    logic [31:0]                   tick_count;
    logic                          counting;
    logic                          seq_done;
    logic [7:0]                    clicks;
    bcc_pkg::result_t              pending[$];
    int unsigned                   errors;

    function new();
      act_level  = bcc_pkg::ACTIVE_LEVEL_RESET;
      timeout    = bcc_pkg::TIMEOUT_RESET;
      locked     = 1'b1;
      held       = 1'b0;
      let_go     = 1'b0;
      edge_tick  = '0;
      tick_count = '0;
      counting   = 1'b0;
      seq_done   = 1'b0;
      clicks     = '0;
      errors     = 0;
    endfunction

    function void set_reg(logic [bcc_pkg::CFG_IDX_W-1:0] idx,
                          logic [bcc_pkg::CFG_DATA_W-1:0] val);
      if (idx == bcc_pkg::CFG_ACTIVE_LEVEL) begin
        act_level = val[0];
      end else if (idx == bcc_pkg::CFG_CLICK_TIMEOUT) begin
        timeout = val[bcc_pkg::TIMEOUT_W-1:0];
      end
    endfunction

    function void drop_button();
      locked = 1'b0;
      held   = 1'b0;
      let_go = 1'b0;
    endfunction

    function void note_input(bcc_pkg::op_e op, logic lvl);
      bcc_pkg::result_t r;
      logic             act;
      logic             skip;
      logic [31:0]      elapsed;
      r = '0;
      r.lock_change = bcc_pkg::LCHG_NONE;
      act = (lvl == act_level);
      case (op)
        bcc_pkg::OP_LOCK: begin
          locked = 1'b1;
          r.lock_change = bcc_pkg::LCHG_LOCK;
        end
        bcc_pkg::OP_UNLOCK: begin
          locked = 1'b0;
          r.lock_change = bcc_pkg::LCHG_UNLOCK;
        end
        bcc_pkg::OP_CLEAR: begin
          drop_button();
        end
        default: begin
          skip = 1'b0;
          // A locked button ignores presses until it reads released.
          if (locked) begin
            if (act) skip = 1'b1;
            else drop_button();
          end
          if (!skip) begin
            if (act) begin
              if (!held) begin
                held = 1'b1;
                edge_tick = tick_count;
                r.press_event = 1'b1;
              end
            end else if (!let_go) begin
              if (held) begin
                held = 1'b0;
                let_go = 1'b1;
                edge_tick = tick_count;
                r.release_event = 1'b1;
              end
            end else begin
              drop_button();
            end
          end
          if (seq_done) begin
            seq_done = 1'b0;
            counting = 1'b0;
            r.click_cleared = 1'b1;
          end else if (let_go) begin
            if (counting) begin
              if (clicks != bcc_pkg::CLICK_MAX) clicks = clicks + 8'd1;
              r.click_more = 1'b1;
            end else begin
              counting = 1'b1;
              clicks = 8'd1;
              r.click_start = 1'b1;
            end
          end else if (!held && counting) begin
            elapsed = tick_count - edge_tick;
            if (elapsed >= timeout) begin
              seq_done = 1'b1;
              r.click_finished = 1'b1;
            end
          end
          tick_count = tick_count + 32'd1;
        end
      endcase
      r.click_count = clicks;
      r.is_pressed  = held;
      r.is_locked   = locked;
      pending.push_back(r);
    endfunction

    function void cmp_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [bcc_pkg::OUT_TDATA_W-1:0] td);
      bcc_pkg::result_t exp_r;
      bcc_pkg::result_t got;
      if (pending.size() == 0) begin
        $display("%0t ns: unexpected result transaction: expected none, actual %06h",
                 $time, td);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      got = bcc_pkg::result_t'(td[bcc_pkg::RES_W-1:0]);
      cmp_field("press_event", exp_r.press_event, got.press_event);
      cmp_field("release_event", exp_r.release_event, got.release_event);
      cmp_field("click_start", exp_r.click_start, got.click_start);
      cmp_field("click_more", exp_r.click_more, got.click_more);
      cmp_field("click_finished", exp_r.click_finished, got.click_finished);
      cmp_field("click_cleared", exp_r.click_cleared, got.click_cleared);
      cmp_field("click_count", exp_r.click_count, got.click_count);
      cmp_field("is_pressed", exp_r.is_pressed, got.is_pressed);
      cmp_field("is_locked", exp_r.is_locked, got.is_locked);
      cmp_field("lock_change", exp_r.lock_change, got.lock_change);
      cmp_field("pad", 0, td[bcc_pkg::OUT_TDATA_W-1:bcc_pkg::RES_W]);
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni = 1'b0;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [bcc_pkg::CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [bcc_pkg::CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata = '0;
  logic [1:0]                      s_axis_tuser = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [bcc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  click_scoreboard sb = new();

  int unsigned                   send_idle_pct = 0;
  int unsigned                   recv_stall_pct = 0;
  int unsigned                   hold_request = 0;
  int unsigned                   items_sent = 0;
  logic                          cur_active = bcc_pkg::ACTIVE_LEVEL_RESET;
  logic [bcc_pkg::TIMEOUT_W-1:0] cur_timeout = bcc_pkg::TIMEOUT_RESET;

  button_click_counter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #1ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_input(bcc_pkg::op_e'(s_axis_tuser), s_axis_tdata[0]);
      end
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  // Called at a falling edge; returns at a falling edge with tvalid still high.
  task automatic send_item(bcc_pkg::op_e op, logic lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, lvl};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_tick(logic pressed);
    send_item(bcc_pkg::OP_TICK, pressed ? cur_active : ~cur_active);
  endtask

  task automatic send_cmd(bcc_pkg::op_e op);
    send_item(op, logic'($urandom_range(1)));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [bcc_pkg::CFG_IDX_W-1:0] idx,
                           logic [bcc_pkg::CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
    if (idx == bcc_pkg::CFG_ACTIVE_LEVEL) cur_active = val[0];
    else cur_timeout = val[bcc_pkg::TIMEOUT_W-1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure(logic lvl, logic [bcc_pkg::TIMEOUT_W-1:0] tmo);
    drain();
    write_reg(bcc_pkg::CFG_ACTIVE_LEVEL, {31'd0, lvl});
    write_reg(bcc_pkg::CFG_CLICK_TIMEOUT, tmo);
  endtask

  // A well-formed burst of 1 to 4 clicks, timed out when the timeout is 40 or less.
  task automatic click_burst();
    int unsigned n_clicks;
    int unsigned gap_hi;
    n_clicks = $urandom_range(1, 4);
    gap_hi = (cur_timeout == 0) ? 1 : ((cur_timeout > 40) ? 40 : cur_timeout);
    for (int i = 0; i < n_clicks; i++) begin
      repeat ($urandom_range(1, 3)) send_tick(1'b1);
      if (i < n_clicks - 1) begin
        repeat ($urandom_range(1, gap_hi)) send_tick(1'b0);
      end else if (cur_timeout <= 40) begin
        repeat (cur_timeout + $urandom_range(1, 3)) send_tick(1'b0);
      end else begin
        repeat ($urandom_range(1, 40)) send_tick(1'b0);
      end
    end
  endtask

  task automatic run_random(int unsigned n_items);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(99) < 15) begin
        send_item(bcc_pkg::op_e'($urandom_range(3)), logic'($urandom_range(1)));
      end else begin
        click_burst();
      end
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: lock handling, edges, counting, timeout, commands.
    write_reg(bcc_pkg::CFG_ACTIVE_LEVEL, {31'd0, 1'b0});
    write_reg(bcc_pkg::CFG_CLICK_TIMEOUT, 32'd3);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    repeat (5) send_tick(1'b0);
    send_cmd(bcc_pkg::OP_LOCK);
    send_tick(1'b0);
    send_cmd(bcc_pkg::OP_UNLOCK);
    send_tick(1'b1);
    send_cmd(bcc_pkg::OP_CLEAR);
    send_tick(1'b1);
    send_cmd(bcc_pkg::OP_LOCK);
    send_tick(1'b1);
    send_cmd(bcc_pkg::OP_UNLOCK);
    send_tick(1'b0);
    send_cmd(bcc_pkg::OP_CLEAR);

    // Saturate the click count with a timeout that never expires.
    send_idle_pct = 23;
    recv_stall_pct = 23;
    configure(1'b1, 32'hFFFF_FFFF);
    repeat (262) begin
      send_tick(1'b1);
      send_tick(1'b0);
    end

    // Random phases; the first one starts with a long receiver hold-off.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    configure(1'b0, 32'd0);
    hold_request = 300;
    run_random(20);
    run_random(40);

    send_idle_pct = 50;
    configure(1'b1, 32'd5);
    run_random(40);

    send_idle_pct = 0;
    recv_stall_pct = 50;
    configure(1'b0, 32'd12);
    run_random(40);

    send_idle_pct = 23;
    recv_stall_pct = 23;
    configure(1'b1, 32'd2);
    run_random(40);

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
